// File: rtl/abtd_pkg.sv
// ----------------------------------------------------------------------------
// abtd_pkg
// Shared types and constants of the adaptive bucket threshold detector.
// ----------------------------------------------------------------------------
package abtd_pkg;

  localparam int BUCKET_W = 4;
  localparam int SAMPLE_W = 16;
  localparam int CNT_W    = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_STEP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GROWTH_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_LIMIT = 2'd2;

  localparam logic [CFG_W-1:0] DECAY_STEP_RST  = 16'd1;
  localparam logic [CFG_W-1:0] GROWTH_STEP_RST = 16'd1;
  localparam logic [CFG_W-1:0] COUNT_LIMIT_RST = 16'd64;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // input action codes
  localparam logic ACT_CLASSIFY = 1'b0;
  localparam logic ACT_LOAD     = 1'b1;

  typedef struct packed {
    logic [CFG_W-1:0] decay_step;
    logic [CFG_W-1:0] growth_step;
    logic [CFG_W-1:0] count_limit;
  } abtd_cfg_t;

  // item as it travels down the row of cells
  typedef struct packed {
    logic                valid;
    logic                action;
    logic [BUCKET_W-1:0] bucket;
    logic [SAMPLE_W-1:0] sample;
    logic                attack;
  } abtd_item_t;

endpackage

// File: rtl/abtd_cell.sv
// ----------------------------------------------------------------------------
// abtd_cell
// One bucket: threshold, hit and idle counters, updated as an item passes.
// ----------------------------------------------------------------------------
module abtd_cell #(
  parameter int CELL_INDEX = 0,
  parameter int VALUE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  abtd_pkg::abtd_cfg_t cfg,
  input  abtd_pkg::abtd_item_t in_item,
  output abtd_pkg::abtd_item_t out_item
);

  localparam int EXT_W = ((VALUE_BITS > abtd_pkg::SAMPLE_W) ? VALUE_BITS
                                                            : abtd_pkg::SAMPLE_W) + 1;
  localparam logic [EXT_W-1:0] THR_MAX_E = EXT_W'({VALUE_BITS{1'b1}});

  logic [VALUE_BITS-1:0]       threshold;
  logic [abtd_pkg::CNT_W-1:0]  hit_count;
  logic [abtd_pkg::CNT_W-1:0]  idle_count;

  logic [VALUE_BITS-1:0]       threshold_next;
  logic [abtd_pkg::CNT_W-1:0]  hit_count_next;
  logic [abtd_pkg::CNT_W-1:0]  idle_count_next;
  abtd_pkg::abtd_item_t        out_item_next;

  logic                        match;
  logic                        hot;
  logic                        cold;
  logic [abtd_pkg::CNT_W-1:0]  hit_inc;
  logic [abtd_pkg::CNT_W-1:0]  idle_inc;
  logic [EXT_W-1:0]            thr_e;
  logic [EXT_W-1:0]            dec_e;
  logic [EXT_W-1:0]            thr_lowered;
  logic [EXT_W-1:0]            thr_raised;
  logic [EXT_W-1:0]            load_e;

  assign match = (32'(in_item.bucket) == CELL_INDEX);

  always_comb begin
    hit_inc  = (hit_count  == abtd_pkg::CNT_MAX) ? hit_count  : hit_count  + 1'b1;
    idle_inc = (idle_count == abtd_pkg::CNT_MAX) ? idle_count : idle_count + 1'b1;
    thr_e    = EXT_W'(threshold);
    dec_e    = EXT_W'(cfg.decay_step);
    load_e   = EXT_W'(in_item.sample);

    threshold_next  = threshold;
    hit_count_next  = hit_count;
    idle_count_next = idle_count;
    hot             = 1'b0;
    cold            = 1'b0;
    thr_lowered     = thr_e;
    thr_raised      = thr_e;
    out_item_next   = in_item;

    if (in_item.valid) begin
      if (in_item.action == abtd_pkg::ACT_LOAD) begin
        if (match) begin
          threshold_next  = (load_e > THR_MAX_E) ? VALUE_BITS'(THR_MAX_E)
                                                 : VALUE_BITS'(load_e);
          hit_count_next  = '0;
          idle_count_next = '0;
        end
      end else begin
        if (match) begin
          if (load_e > thr_e) begin
            out_item_next.attack = 1'b1;
          end
          hit_count_next  = hit_inc;
          idle_count_next = '0;
        end else begin
          idle_count_next = idle_inc;
        end
        hot  = (hit_count_next  >= cfg.count_limit);
        cold = (idle_count_next >= cfg.count_limit);
        // lowering first, then raising on the result
        if (hot) begin
          thr_lowered    = (thr_e > dec_e) ? thr_e - dec_e : '0;
          hit_count_next = '0;
        end
        thr_raised = thr_lowered;
        if (cold) begin
          thr_raised      = thr_lowered + EXT_W'(cfg.growth_step);
          if (thr_raised > THR_MAX_E) begin
            thr_raised = THR_MAX_E;
          end
          idle_count_next = '0;
        end
        threshold_next = VALUE_BITS'(thr_raised);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold  <= '0;
      hit_count  <= '0;
      idle_count <= '0;
      out_item   <= '0;
    end else if (en) begin
      threshold  <= threshold_next;
      hit_count  <= hit_count_next;
      idle_count <= idle_count_next;
      out_item   <= out_item_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_match_idle_clear: assert property (@(posedge clk) disable iff (rst)
    (en && in_item.valid && match) |=> (idle_count == '0))
    else $error("matched bucket kept a nonzero idle count");

  a_hit_below_limit: assert property (@(posedge clk) disable iff (rst)
    (en && in_item.valid && in_item.action == abtd_pkg::ACT_CLASSIFY)
      |=> (hit_count == '0 || hit_count < $past(cfg.count_limit)))
    else $error("hit count left at or above limit after adaptation");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> ($stable(threshold) && $stable(hit_count) && $stable(idle_count)))
    else $error("bucket state changed while the row was stalled");
`endif

endmodule

// File: rtl/adaptive_bucket_threshold_detector_unit.sv
// ----------------------------------------------------------------------------
// adaptive_bucket_threshold_detector_unit
// Per-bucket adaptive threshold detector built as a row of bucket cells.
// ----------------------------------------------------------------------------
// the item passes along the row of cells in order, each cell registering it
// throughput: one item per cycle unless stalled; every cell updates on a classify item
// the whole row stalls together while the output register holds an untaken result
// reset: thresholds and counters cleared, decay and growth steps 1, count limit 64
module adaptive_bucket_threshold_detector_unit #(
  parameter int NUM_BUCKETS = 16,
  parameter int VALUE_BITS  = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration writes
  input  logic                               cfg_we,
  input  logic [abtd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [abtd_pkg::CFG_W-1:0]         cfg_data,
  // input items
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [23:0]                        s_tdata,  // bucket[3:0], sample[19:4], zero pad
  input  logic [0:0]                         s_tuser,  // action
  // results
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [7:0]                         m_tdata   // attack, zero pad
);

  abtd_pkg::abtd_cfg_t  cfg;
  abtd_pkg::abtd_item_t stage [0:NUM_BUCKETS];
  logic                 en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.decay_step  <= abtd_pkg::DECAY_STEP_RST;
      cfg.growth_step <= abtd_pkg::GROWTH_STEP_RST;
      cfg.count_limit <= abtd_pkg::COUNT_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        abtd_pkg::REG_DECAY_STEP:  cfg.decay_step  <= cfg_data;
        abtd_pkg::REG_GROWTH_STEP: cfg.growth_step <= cfg_data;
        abtd_pkg::REG_COUNT_LIMIT: cfg.count_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en       = !stage[NUM_BUCKETS].valid || m_tready;
  assign s_tready = en;

  always_comb begin
    stage[0].valid  = s_tvalid;
    stage[0].action = s_tuser[0];
    stage[0].bucket = s_tdata[3:0];
    stage[0].sample = s_tdata[19:4];
    stage[0].attack = 1'b0;
  end

  for (genvar i = 0; i < NUM_BUCKETS; i++) begin : g_cell
    abtd_cell #(
      .CELL_INDEX (i),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .cfg      (cfg),
      .in_item  (stage[i]),
      .out_item (stage[i+1])
    );
  end

  assign m_tvalid = stage[NUM_BUCKETS].valid;
  assign m_tdata  = {7'd0, stage[NUM_BUCKETS].attack};

`ifndef NO_ASSERTIONS
  a_load_no_attack: assert property (@(posedge clk) disable iff (rst)
    (stage[NUM_BUCKETS].valid && stage[NUM_BUCKETS].action == abtd_pkg::ACT_LOAD)
      |-> !stage[NUM_BUCKETS].attack)
    else $error("load transfer flagged an attack");

  a_range_no_attack: assert property (@(posedge clk) disable iff (rst)
    (stage[NUM_BUCKETS].valid && 32'(stage[NUM_BUCKETS].bucket) >= NUM_BUCKETS)
      |-> !stage[NUM_BUCKETS].attack)
    else $error("out of range bucket flagged an attack");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_stall_first: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(stage[1]))
    else $error("first cell moved while the row was stalled");
`endif

endmodule

// File: bench/adaptive_bucket_threshold_detector_unit_tb.sv
// ----------------------------------------------------------------------------
// adaptive_bucket_threshold_detector_unit_tb
// Stream-level check of the bucket threshold detector: a table of directed
// events, then phases of biased random events under different register
// settings and handshake idling, each result compared with the table or a local model.
// ----------------------------------------------------------------------------
module adaptive_bucket_threshold_detector_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NB       = 16;
  localparam int LATENCY  = NB;
  localparam int N_PHASES = 8;
  localparam int PHASE_ITEMS = 75;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic                          act;
    logic [abtd_pkg::BUCKET_W-1:0] bkt;
    logic [abtd_pkg::SAMPLE_W-1:0] smp;
    logic                          typed;
    logic                          att;
  } dir_row_t;

  typedef struct packed {
    logic [abtd_pkg::CFG_W-1:0] decay;
    logic [abtd_pkg::CFG_W-1:0] growth;
    logic [abtd_pkg::CFG_W-1:0] limit;
    logic                       program_regs;
    logic                       shuffle;
    idle_mode_t                 mode;
  } phase_t;

  // thresholds start at zero, counters far from the limit of 64
  localparam dir_row_t DIR_TAB [20] = '{
    '{abtd_pkg::ACT_CLASSIFY, 4'd0,  16'h0000, 1'b1, 1'b0},
    '{abtd_pkg::ACT_CLASSIFY, 4'd0,  16'h0001, 1'b1, 1'b1},
    '{abtd_pkg::ACT_CLASSIFY, 4'd15, 16'hFFFF, 1'b1, 1'b1},
    '{abtd_pkg::ACT_LOAD,     4'd15, 16'hFFFF, 1'b1, 1'b0},
    '{abtd_pkg::ACT_CLASSIFY, 4'd15, 16'hFFFF, 1'b1, 1'b0},
    '{abtd_pkg::ACT_CLASSIFY, 4'd15, 16'hFFFE, 1'b1, 1'b0},
    '{abtd_pkg::ACT_LOAD,     4'd3,  16'h1234, 1'b1, 1'b0},
    '{abtd_pkg::ACT_CLASSIFY, 4'd3,  16'h1234, 1'b1, 1'b0},
    '{abtd_pkg::ACT_CLASSIFY, 4'd3,  16'h1235, 1'b1, 1'b1},
    '{abtd_pkg::ACT_LOAD,     4'd7,  16'hAAAA, 1'b1, 1'b0},
    '{abtd_pkg::ACT_CLASSIFY, 4'd7,  16'h5555, 1'b1, 1'b0},
    '{abtd_pkg::ACT_CLASSIFY, 4'd7,  16'hFFFF, 1'b1, 1'b1},
    '{abtd_pkg::ACT_LOAD,     4'd8,  16'h5555, 1'b1, 1'b0},
    '{abtd_pkg::ACT_CLASSIFY, 4'd8,  16'hAAAA, 1'b1, 1'b1},
    '{abtd_pkg::ACT_LOAD,     4'd0,  16'h0000, 1'b1, 1'b0},
    '{abtd_pkg::ACT_CLASSIFY, 4'd0,  16'hFFFF, 1'b1, 1'b1},
    '{abtd_pkg::ACT_LOAD,     4'd12, 16'h8000, 1'b1, 1'b0},
    '{abtd_pkg::ACT_CLASSIFY, 4'd12, 16'h7FFF, 1'b0, 1'b0},
    '{abtd_pkg::ACT_CLASSIFY, 4'd12, 16'h8001, 1'b0, 1'b0},
    '{abtd_pkg::ACT_CLASSIFY, 4'd5,  16'h0001, 1'b0, 1'b0}
  };

  localparam phase_t PHASES [N_PHASES] = '{
    '{16'd1,     16'd1,     16'd64,    1'b0, 1'b0, IDLE_NONE},
    '{16'd0,     16'd0,     16'd1,     1'b1, 1'b0, IDLE_SEND},
    '{16'hFFFF,  16'hFFFF,  16'd1,     1'b1, 1'b0, IDLE_RECV},
    '{16'd3,     16'd7,     16'd0,     1'b1, 1'b0, IDLE_BOTH},
    '{16'd100,   16'd250,   16'd5,     1'b1, 1'b0, IDLE_SEND},
    '{16'hFFFF,  16'd0,     16'hFFFF,  1'b1, 1'b0, IDLE_RECV},
    '{16'd0,     16'd0,     16'd0,     1'b1, 1'b1, IDLE_BOTH},
    '{16'd1,     16'hFFFF,  16'd3,     1'b1, 1'b0, IDLE_NONE}
  };

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [abtd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [abtd_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [23:0]                    s_tdata = '0;  // bucket[3:0], sample[19:4], zero pad
  logic [0:0]                     s_tuser = '0;  // action
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [7:0]                     m_tdata;       // attack, zero pad

  // local model of the bucket state and registers
  logic [abtd_pkg::SAMPLE_W-1:0] thr_m  [NB];
  logic [abtd_pkg::CNT_W-1:0]    hit_m  [NB];
  logic [abtd_pkg::CNT_W-1:0]    idle_m [NB];
  logic [abtd_pkg::CFG_W-1:0]    decay_m;
  logic [abtd_pkg::CFG_W-1:0]    growth_m;
  logic [abtd_pkg::CFG_W-1:0]    limit_m;

  logic                          attack_q [$];
  idle_mode_t                    idle_mode = IDLE_NONE;
  int                            errors = 0;
  logic [abtd_pkg::BUCKET_W-1:0] hot_base = '0;

  adaptive_bucket_threshold_detector_unit #(
    .NUM_BUCKETS(NB),
    .VALUE_BITS (abtd_pkg::SAMPLE_W)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #400us;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int send_idle_pct();
    case (idle_mode)
      IDLE_SEND: return 53;
      IDLE_BOTH: return 23;
      default:   return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct();
    case (idle_mode)
      IDLE_RECV: return 53;
      IDLE_BOTH: return 23;
      default:   return 0;
    endcase
  endfunction

  // advances the bucket state by one item and returns its attack flag
  function automatic logic predict_attack(input logic act,
                                          input logic [abtd_pkg::BUCKET_W-1:0] bkt,
                                          input logic [abtd_pkg::SAMPLE_W-1:0] smp);
    logic                      att;
    logic [abtd_pkg::SAMPLE_W:0] sum;
    att = 1'b0;
    if (act == abtd_pkg::ACT_LOAD) begin
      thr_m[bkt]  = smp;
      hit_m[bkt]  = '0;
      idle_m[bkt] = '0;
      return 1'b0;
    end
    for (int i = 0; i < NB; i++) begin
      if (i == int'(bkt)) begin
        att = (smp > thr_m[i]);
        if (hit_m[i] != abtd_pkg::CNT_MAX) hit_m[i] = hit_m[i] + 1'b1;
        idle_m[i] = '0;
      end else if (idle_m[i] != abtd_pkg::CNT_MAX) begin
        idle_m[i] = idle_m[i] + 1'b1;
      end
    end
    // lowering first, then raising; both may hit one bucket
    for (int i = 0; i < NB; i++) begin
      if (hit_m[i] >= limit_m) begin
        thr_m[i] = (thr_m[i] > decay_m) ? thr_m[i] - decay_m : '0;
        hit_m[i] = '0;
      end
      if (idle_m[i] >= limit_m) begin
        sum = {1'b0, thr_m[i]} + {1'b0, growth_m};
        thr_m[i]  = sum[abtd_pkg::SAMPLE_W] ? {abtd_pkg::SAMPLE_W{1'b1}}
                                            : sum[abtd_pkg::SAMPLE_W-1:0];
        idle_m[i] = '0;
      end
    end
    return att;
  endfunction

  task automatic send_event(input logic act, input logic [abtd_pkg::BUCKET_W-1:0] bkt,
                            input logic [abtd_pkg::SAMPLE_W-1:0] smp, input logic typed,
                            input logic typed_att);
    logic att;
    while ($urandom_range(99) < send_idle_pct()) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {4'b0, smp, bkt};
    do @(posedge clk); while (!s_tready);
    att = predict_attack(act, bkt, smp);
    attack_q.push_back(typed ? typed_att : att);
  endtask

  task automatic random_event();
    logic                          act;
    logic [abtd_pkg::BUCKET_W-1:0] bkt;
    logic [abtd_pkg::SAMPLE_W-1:0] smp;
    int                            r;
    act = ($urandom_range(99) < 8) ? abtd_pkg::ACT_LOAD : abtd_pkg::ACT_CLASSIFY;
    // a few hot buckets so hit counters reach the limit
    if ($urandom_range(99) < 65) bkt = abtd_pkg::BUCKET_W'(hot_base + $urandom_range(2));
    else bkt = abtd_pkg::BUCKET_W'($urandom_range(NB - 1));
    r = $urandom_range(99);
    if (r < 35)      smp = thr_m[bkt] + abtd_pkg::SAMPLE_W'($urandom_range(2)) - 1'b1;
    else if (r < 45) smp = thr_m[bkt];
    else if (r < 55) smp = '0;
    else if (r < 65) smp = {abtd_pkg::SAMPLE_W{1'b1}};
    else             smp = abtd_pkg::SAMPLE_W'($urandom);
    send_event(act, bkt, smp, 1'b0, 1'b0);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (attack_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // three consecutive register writes, enable held high across them
  task automatic set_config(input logic [abtd_pkg::CFG_W-1:0] d,
                            input logic [abtd_pkg::CFG_W-1:0] g,
                            input logic [abtd_pkg::CFG_W-1:0] l);
    cfg_we    <= 1'b1;
    cfg_index <= abtd_pkg::REG_DECAY_STEP;
    cfg_data  <= d;
    @(posedge clk);
    cfg_index <= abtd_pkg::REG_GROWTH_STEP;
    cfg_data  <= g;
    @(posedge clk);
    cfg_index <= abtd_pkg::REG_COUNT_LIMIT;
    cfg_data  <= l;
    @(posedge clk);
    cfg_we <= 1'b0;
    decay_m  = d;
    growth_m = g;
    limit_m  = l;
  endtask

  // receiver side: stall pattern and result check
  always @(posedge clk) begin
    logic exp_att;
    if (!rst && m_tvalid && m_tready) begin
      if (attack_q.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $realtime, m_tdata);
        errors++;
      end else begin
        exp_att = attack_q.pop_front();
        if (m_tdata !== {7'b0, exp_att}) begin
          $display("%0t attack mismatch: expected %h actual %h", $realtime,
                   {7'b0, exp_att}, m_tdata);
          errors++;
        end
      end
    end
    m_tready <= ($urandom_range(99) >= recv_stall_pct());
  end

  initial begin
    phase_t ph;
    for (int i = 0; i < NB; i++) begin
      thr_m[i]  = '0;
      hit_m[i]  = '0;
      idle_m[i] = '0;
    end
    decay_m  = abtd_pkg::DECAY_STEP_RST;
    growth_m = abtd_pkg::GROWTH_STEP_RST;
    limit_m  = abtd_pkg::COUNT_LIMIT_RST;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIR_TAB[k])
      send_event(DIR_TAB[k].act, DIR_TAB[k].bkt, DIR_TAB[k].smp,
                 DIR_TAB[k].typed, DIR_TAB[k].att);

    for (int p = 0; p < N_PHASES; p++) begin
      ph = PHASES[p];
      drain_results();
      if (ph.shuffle)
        set_config(abtd_pkg::CFG_W'($urandom_range(300)),
                   abtd_pkg::CFG_W'($urandom_range(3000)),
                   abtd_pkg::CFG_W'($urandom_range(1, 20)));
      else if (ph.program_regs)
        set_config(ph.decay, ph.growth, ph.limit);
      idle_mode = ph.mode;
      hot_base  = abtd_pkg::BUCKET_W'($urandom_range(NB - 1));
      repeat (PHASE_ITEMS) random_event();
    end

    drain_results();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
